>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// shared assertion wrappers, clocked on the rising edge and off in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check under a synchronous active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant, held in every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

>>> rtl/tea_pkg.sv
// ---------------------------------------------------------------------------
// tea_pkg
// types, constants and the mixing function of the tea block cipher
// ---------------------------------------------------------------------------
package tea_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // key register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ZERO  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THREE = 8'd3;

    // operation select
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] block_left;
        logic [WORD_W-1:0] block_right;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] result_left;
        logic [WORD_W-1:0] result_right;
    } t_out_word;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    // one block in flight through the round pipeline
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } t_blk;

    function automatic logic [WORD_W-1:0] mix_half(
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
    endfunction

    // delta times n, modulo 2^32; only called with elaboration constants
    function automatic logic [WORD_W-1:0] delta_times(input int unsigned n);
        logic [2*WORD_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, TEA_DELTA} * (2*WORD_W)'(n);
        return prod[WORD_W-1:0];
    endfunction

endpackage

>>> rtl/tea_block_cipher.sv
// throughput: one block per cycle while o_in_stall is low
// one register stage per half-round plus an output register
// a two-entry output buffer (output register and skid) decouples the output stall from the input
// reset: synchronous active low; clears all valid bits and the four key words to zero
// ---------------------------------------------------------------------------
// tea_block_cipher
// pipelined tea encrypt/decrypt of one 64-bit block per cycle when not stalled, 128-bit key
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tea_block_cipher
    import tea_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam int unsigned STAGES = 2 * ROUND_COUNT;

    t_key r_key;
    t_key n_key;

    logic w_valid [STAGES+1];
    t_blk w_blk   [STAGES+1];
    logic w_pipe_en;

    logic r_out_v;
    logic n_out_v;
    t_blk r_out;
    t_blk n_out;
    logic r_skid_v;
    logic n_skid_v;
    t_blk r_skid;
    t_blk n_skid;
    logic w_out_free;

    // key registers
    always_comb begin
        n_key = r_key;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_ZERO:  n_key.k0 = i_cfg_data;
                CFG_KEY_ONE:   n_key.k1 = i_cfg_data;
                CFG_KEY_TWO:   n_key.k2 = i_cfg_data;
                CFG_KEY_THREE: n_key.k3 = i_cfg_data;
                default:       n_key    = r_key;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_cfg_ready = 1'b1;

    // round pipeline, frozen only while the skid entry is occupied
    assign w_pipe_en  = !r_skid_v;
    assign o_in_stall = r_skid_v;

    assign w_valid[0]      = i_in_valid;
    assign w_blk[0].mode   = i_in_word.mode;
    assign w_blk[0].left   = i_in_word.block_left;
    assign w_blk[0].right  = i_in_word.block_right;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        tea_stage #(
            .ROUND_COUNT (ROUND_COUNT),
            .ROUND       (s / 2),
            .HALF        (s % 2)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_pipe_en),
            .i_valid (w_valid[s]),
            .i_blk   (w_blk[s]),
            .i_key   (r_key),
            .o_valid (w_valid[s+1]),
            .o_blk   (w_blk[s+1])
        );
    end

    // output register with one skid entry behind it
    assign w_out_free = !r_out_v || !i_out_stall;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (r_skid_v) begin
            if (!i_out_stall) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (w_valid[STAGES]) begin
            if (w_out_free) begin
                n_out   = w_blk[STAGES];
                n_out_v = 1'b1;
            end else begin
                n_skid   = w_blk[STAGES];
                n_skid_v = 1'b1;
            end
        end else if (w_out_free) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid             = r_out_v;
    assign o_out_word.result_left  = r_out.left;
    assign o_out_word.result_right = r_out.right;

    `ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_v || r_out_v, "skid without output")
    `ASSERT_CLK(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_v) |-> $past(!w_out_free), "skid early")
    `ASSERT_CLK(a_skid_drain, i_clk, i_rst_n, r_skid_v && !i_out_stall |=> !r_skid_v, "skid held")
    `ASSERT_CLK(a_frozen, i_clk, i_rst_n, r_skid_v |=> $stable(w_valid[STAGES]), "pipeline moved")

endmodule

>>> rtl/tea_stage.sv
// ---------------------------------------------------------------------------
// tea_stage
// one registered half-round; encrypt and decrypt share the stage
// ---------------------------------------------------------------------------
module tea_stage
    import tea_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = 32,
    parameter int unsigned ROUND       = 0,
    parameter int unsigned HALF        = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_blk i_blk,
    input  t_key i_key,
    output logic o_valid,
    output t_blk o_blk
);

    // decryption walks the rounds backwards
    localparam logic [WORD_W-1:0] ENC_SUM = delta_times(ROUND + 1);
    localparam logic [WORD_W-1:0] DEC_SUM = delta_times(ROUND_COUNT - ROUND);

    logic              r_valid;
    t_blk              r_blk;
    t_blk              n_blk;
    logic [WORD_W-1:0] w_sum;
    logic [WORD_W-1:0] w_mix;

    always_comb begin
        w_sum = (i_blk.mode == MODE_DECRYPT) ? DEC_SUM : ENC_SUM;
        n_blk = i_blk;
        if (HALF == 0) begin
            if (i_blk.mode == MODE_DECRYPT) begin
                w_mix       = mix_half(i_blk.left, w_sum, i_key.k2, i_key.k3);
                n_blk.right = i_blk.right - w_mix;
            end else begin
                w_mix      = mix_half(i_blk.right, w_sum, i_key.k0, i_key.k1);
                n_blk.left = i_blk.left + w_mix;
            end
        end else begin
            if (i_blk.mode == MODE_DECRYPT) begin
                w_mix      = mix_half(i_blk.right, w_sum, i_key.k0, i_key.k1);
                n_blk.left = i_blk.left - w_mix;
            end else begin
                w_mix       = mix_half(i_blk.left, w_sum, i_key.k2, i_key.k3);
                n_blk.right = i_blk.right + w_mix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule
